>>> rtl/core/psched_pkg.sv
// ----------------------------------------------------------------------------
// psched_pkg
// Shared types and command codes for the process state scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package psched_pkg;

    // command codes as they arrive on the request channel
    localparam logic [2:0] MODE_STOP     = 3'd0;
    localparam logic [2:0] MODE_READY    = 3'd1;
    localparam logic [2:0] MODE_SLEEP    = 3'd2;
    localparam logic [2:0] MODE_BLOCK    = 3'd3;
    localparam logic [2:0] MODE_DISPATCH = 3'd4;
    localparam logic [2:0] MODE_TICK     = 3'd5;
    localparam logic [2:0] MODE_KILL     = 3'd6;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  pid;
        logic [15:0] delay;
    } req_t;

    typedef struct packed {
        logic [7:0] result_pid;
        logic [7:0] running_pid;
        logic [4:0] woken_count;
        logic       status;
    } rsp_t;

    // decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_STOP,
        OP_READY,
        OP_SLEEP,
        OP_BLOCK,
        OP_DISPATCH,
        OP_TICK,
        OP_KILL,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  pid;
        logic [15:0] delay;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DISP_WAIT,
        S_TICK_RD,
        S_TICK_CMP,
        S_KILL_CMP,
        S_IO_FREE,
        S_IO_RD,
        S_IO_CMP,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/psched_ram.sv
// ----------------------------------------------------------------------------
// psched_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psched_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/psched_front.sv
// ----------------------------------------------------------------------------
// psched_front
// Accepts requests, decodes the mode and masks the pid, and holds them in a
// two-entry command queue for the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psched_front
    import psched_pkg::*;
#(
    parameter int PID_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      cmd_valid,
    output cmd_t      cmd,
    input  wire logic cmd_pop
);

    localparam logic [7:0] PID_MASK =
        (PID_BITS >= 8) ? 8'hFF : 8'((1 << PID_BITS) - 1);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       dec;
    logic       push;

    // decode the request
    always_comb
    begin
        dec.pid   = req.pid & PID_MASK;
        dec.delay = req.delay;
        case (req.mode)
            MODE_STOP:     dec.op = OP_STOP;
            MODE_READY:    dec.op = OP_READY;
            MODE_SLEEP:    dec.op = OP_SLEEP;
            MODE_BLOCK:    dec.op = OP_BLOCK;
            MODE_DISPATCH: dec.op = OP_DISPATCH;
            MODE_TICK:     dec.op = OP_TICK;
            MODE_KILL:     dec.op = OP_KILL;
            default:       dec.op = OP_NONE;
        endcase
    end

    // queue control
    always_comb
    begin
        req_stall   = (cnt_reg == 2'd2);
        push        = req_valid && !req_stall;
        cmd_valid   = (cnt_reg != 2'd0);
        cmd         = q_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + (push ? 2'd1 : 2'd0) - (cmd_pop ? 2'd1 : 2'd0);
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/psched_back.sv
// ----------------------------------------------------------------------------
// psched_back
// Executes scheduler commands: running slot, ready and timed queues in RAM,
// I/O wait list walked slot by slot, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module psched_back
    import psched_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int IO_SLOTS    = 10
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IAW = $clog2(IO_SLOTS);
    localparam int IW  = $clog2(IO_SLOTS + 1);

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [7:0]      running_reg, running_next;
    logic [31:0]     clock_reg, clock_next;
    logic [AW-1:0]   r_head_reg, r_head_next, r_tail_reg, r_tail_next;
    logic [CW-1:0]   r_count_reg, r_count_next;
    logic [AW-1:0]   t_head_reg, t_head_next, t_tail_reg, t_tail_next;
    logic [CW-1:0]   t_count_reg, t_count_next;
    logic [IO_SLOTS-1:0] io_valid_reg, io_valid_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [7:0]      held_reg, held_next;
    logic [7:0]      res_reg, res_next;
    logic [4:0]      woken_reg, woken_next;
    logic            status_reg, status_next;
    logic            out_valid_reg, out_valid_next;
    rsp_t            out_reg, out_next;

    logic            r_we, t_we, io_we;
    logic [7:0]      r_wdata, r_rdata, io_wdata, io_rdata;
    logic [39:0]     t_wdata, t_rdata;
    logic [IAW-1:0]  io_addr;
    logic [7:0]      io_val;
    logic            out_free;
    logic            r_full, t_full, r_empty, t_empty, idx_end;

    // storage
    psched_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_ready_ram (
        .clk(clk), .we(r_we), .waddr(r_tail_reg), .wdata(r_wdata),
        .raddr(r_head_reg), .rdata(r_rdata)
    );

    psched_ram #(.WIDTH(40), .DEPTH(QUEUE_DEPTH)) u_timed_ram (
        .clk(clk), .we(t_we), .waddr(t_tail_reg), .wdata(t_wdata),
        .raddr(t_head_reg), .rdata(t_rdata)
    );

    psched_ram #(.WIDTH(8), .DEPTH(IO_SLOTS)) u_io_ram (
        .clk(clk), .we(io_we), .waddr(io_addr), .wdata(io_wdata),
        .raddr(io_addr), .rdata(io_rdata)
    );

    // status terms
    always_comb
    begin
        out_free = !out_valid_reg || !rsp_stall;
        r_full   = (r_count_reg == CW'(QUEUE_DEPTH));
        t_full   = (t_count_reg == CW'(QUEUE_DEPTH));
        r_empty  = (r_count_reg == '0);
        t_empty  = (t_count_reg == '0);
        idx_end  = (idx_reg == IW'(IO_SLOTS));
        io_addr  = idx_reg[IAW-1:0];
        io_val   = io_valid_reg[io_addr] ? io_rdata : 8'd0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_SLEEP, OP_DISPATCH: state_next = S_DISP_WAIT;
                    OP_BLOCK:
                        state_next = (running_reg == 8'd0) ? S_DISP_WAIT : S_IO_FREE;
                    OP_TICK: state_next = S_TICK_RD;
                    OP_KILL:
                        state_next = (running_reg == cmd_reg.pid) ? S_DONE : S_KILL_CMP;
                    default: state_next = S_DONE;
                endcase
            end
            S_DISP_WAIT: state_next = S_DONE;
            S_TICK_RD:   state_next = t_empty ? S_DONE : S_TICK_CMP;
            S_TICK_CMP:
                state_next = (t_rdata[31:0] == clock_reg) ? S_TICK_RD : S_DONE;
            S_KILL_CMP:
            begin
                if ((!r_empty && r_rdata == cmd_reg.pid)
                    || (!t_empty && t_rdata[39:32] == cmd_reg.pid))
                    state_next = S_DONE;
                else
                    state_next = S_IO_RD;
            end
            S_IO_FREE:
            begin
                if (idx_end || !io_valid_reg[io_addr])
                    state_next = S_DISP_WAIT;
            end
            S_IO_RD:  state_next = idx_end ? S_DONE : S_IO_CMP;
            S_IO_CMP: state_next = (io_val == cmd_reg.pid) ? S_DONE : S_IO_RD;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        running_next   = running_reg;
        clock_next     = clock_reg;
        r_head_next    = r_head_reg;
        r_tail_next    = r_tail_reg;
        r_count_next   = r_count_reg;
        t_head_next    = t_head_reg;
        t_tail_next    = t_tail_reg;
        t_count_next   = t_count_reg;
        io_valid_next  = io_valid_reg;
        idx_next       = idx_reg;
        held_next      = held_reg;
        res_next       = res_reg;
        woken_next     = woken_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = rsp_stall ? out_valid_reg : 1'b0;
        cmd_pop        = 1'b0;
        r_we           = 1'b0;
        r_wdata        = cmd_reg.pid;
        t_we           = 1'b0;
        t_wdata        = {running_reg, clock_reg + 32'(cmd_reg.delay)};
        io_we          = 1'b0;
        io_wdata       = held_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    cmd_next    = cmd;
                    res_next    = 8'd0;
                    woken_next  = 5'd0;
                    status_next = 1'b0;
                    idx_next    = '0;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_STOP:
                    begin
                        res_next     = running_reg;
                        running_next = 8'd0;
                    end
                    OP_READY:
                    begin
                        if (cmd_reg.pid != 8'd0)
                        begin
                            if (r_full)
                                status_next = 1'b1;
                            else
                            begin
                                r_we         = 1'b1;
                                r_tail_next  = (r_tail_reg == AW'(QUEUE_DEPTH - 1))
                                               ? '0 : r_tail_reg + 1'b1;
                                r_count_next = r_count_reg + 1'b1;
                            end
                        end
                    end
                    OP_SLEEP:
                    begin
                        running_next = 8'd0;
                        if (running_reg != 8'd0)
                        begin
                            if (t_full)
                                status_next = 1'b1;
                            else
                            begin
                                t_we         = 1'b1;
                                t_tail_next  = (t_tail_reg == AW'(QUEUE_DEPTH - 1))
                                               ? '0 : t_tail_reg + 1'b1;
                                t_count_next = t_count_reg + 1'b1;
                            end
                        end
                    end
                    OP_BLOCK:
                    begin
                        held_next    = running_reg;
                        running_next = 8'd0;
                    end
                    OP_TICK:
                        clock_next = clock_reg + 32'd1;
                    OP_KILL:
                    begin
                        if (running_reg == cmd_reg.pid)
                            running_next = 8'd0;
                    end
                    default: ;
                endcase
            end
            // pop the ready head into the running slot
            S_DISP_WAIT:
            begin
                if (!r_empty)
                begin
                    running_next = r_rdata;
                    r_head_next  = (r_head_reg == AW'(QUEUE_DEPTH - 1))
                                   ? '0 : r_head_reg + 1'b1;
                    r_count_next = r_count_reg - 1'b1;
                end
                else if (cmd_reg.op == OP_DISPATCH)
                    running_next = 8'd0;
                if (cmd_reg.op == OP_DISPATCH)
                    res_next = r_empty ? 8'd0 : r_rdata;
            end
            S_TICK_RD: ;
            // move a due timed head to the ready queue, or drop it and set status when ready is full
            S_TICK_CMP:
            begin
                if (t_rdata[31:0] == clock_reg)
                begin
                    t_head_next  = (t_head_reg == AW'(QUEUE_DEPTH - 1))
                                   ? '0 : t_head_reg + 1'b1;
                    t_count_next = t_count_reg - 1'b1;
                    r_wdata      = t_rdata[39:32];
                    if (r_full)
                        status_next = 1'b1;
                    else
                    begin
                        r_we         = 1'b1;
                        r_tail_next  = (r_tail_reg == AW'(QUEUE_DEPTH - 1))
                                       ? '0 : r_tail_reg + 1'b1;
                        r_count_next = r_count_reg + 1'b1;
                        woken_next   = woken_reg + 5'd1;
                    end
                end
            end
            // kill against the queue heads
            S_KILL_CMP:
            begin
                if (!r_empty && r_rdata == cmd_reg.pid)
                begin
                    r_head_next  = (r_head_reg == AW'(QUEUE_DEPTH - 1))
                                   ? '0 : r_head_reg + 1'b1;
                    r_count_next = r_count_reg - 1'b1;
                end
                else if (!t_empty && t_rdata[39:32] == cmd_reg.pid)
                begin
                    t_head_next  = (t_head_reg == AW'(QUEUE_DEPTH - 1))
                                   ? '0 : t_head_reg + 1'b1;
                    t_count_next = t_count_reg - 1'b1;
                end
            end
            // look for the first empty i/o slot
            S_IO_FREE:
            begin
                if (idx_end)
                    status_next = 1'b1;
                else if (!io_valid_reg[io_addr])
                begin
                    io_we                  = 1'b1;
                    io_valid_next[io_addr] = 1'b1;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_IO_RD: ;
            // kill against one i/o slot
            S_IO_CMP:
            begin
                if (io_val == cmd_reg.pid)
                    io_valid_next[io_addr] = 1'b0;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.result_pid  = res_reg;
                    out_next.running_pid = running_reg;
                    out_next.woken_count = woken_reg;
                    out_next.status      = status_reg;
                end
            end
            default: ;
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // control and scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= 8'd0;
            clock_reg     <= 32'd0;
            r_head_reg    <= '0;
            r_tail_reg    <= '0;
            r_count_reg   <= '0;
            t_head_reg    <= '0;
            t_tail_reg    <= '0;
            t_count_reg   <= '0;
            io_valid_reg  <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            clock_reg     <= clock_next;
            r_head_reg    <= r_head_next;
            r_tail_reg    <= r_tail_next;
            r_count_reg   <= r_count_next;
            t_head_reg    <= t_head_next;
            t_tail_reg    <= t_tail_next;
            t_count_reg   <= t_count_next;
            io_valid_reg  <= io_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command payload and result fields
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        held_reg   <= held_next;
        res_reg    <= res_next;
        woken_reg  <= woken_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    // queue counts stay within depth
    a_r_count: assert property (@(posedge clk) disable iff (!rst_n)
        r_count_reg <= CW'(QUEUE_DEPTH))
        else $error("ready count beyond depth");

    a_t_count: assert property (@(posedge clk) disable iff (!rst_n)
        t_count_reg <= CW'(QUEUE_DEPTH))
        else $error("timed count beyond depth");

    // slot walk never runs past the list
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IW'(IO_SLOTS))
        else $error("i/o slot index out of range");

    // a finished command always shows up as a response
    a_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (rsp_valid && state_reg == S_IDLE))
        else $error("finished command not presented");

    // a taken command starts execution with cleared result fields
    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == S_EXEC && woken_reg == 5'd0 && !status_reg))
        else $error("command started with stale result fields");

endmodule

`default_nettype wire

>>> rtl/core/process_state_scheduler_top.sv
// ----------------------------------------------------------------------------
// process_state_scheduler_top
// Process scheduler with ready, timed-wait and i/o wait tracking.
// ----------------------------------------------------------------------------
// sequencing: stop, ready, none and kill of the running pid finish straight
//   after execute; sleep, dispatch and block while idle add a dispatch step;
//   tick examines timed entries from the head one at a time; block and kill
//   walk the i/o list slot by slot (IO_SLOTS bounds the walk)
// throughput: one command at a time in the execution sequencer, a
//   two-entry command queue takes requests while it works, until it is full
// reset: asynchronous, clears running slot, clock, queue pointers and slots
`default_nettype none

module process_state_scheduler_top
    import psched_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int IO_SLOTS    = 10,
    parameter int PID_BITS    = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // request decode and command queue
    psched_front #(.PID_BITS(PID_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // command execution
    psched_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .IO_SLOTS(IO_SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
